// ===== rtl/assert_macros.svh =====
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== rtl/lphs_pkg.sv =====
// Types and constants of the linear probing hash set.
package lphs_pkg;

  localparam int KEY_W    = 31;
  localparam int KIND_W   = 2;
  localparam int SIZE_W   = 5;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int SSTATE_W = 2;
  localparam int ENTRY_W  = KEY_W + SSTATE_W;
  localparam int COUNT_W  = 5;

  localparam int MOD_BITS_PER_CYCLE = 4;
  localparam int MOD_DVD_W          = 32;
  localparam int MOD_CYCLES         = MOD_DVD_W / MOD_BITS_PER_CYCLE;
  localparam int MOD_CNT_W          = $clog2(MOD_CYCLES);

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  localparam logic [SSTATE_W-1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [SSTATE_W-1:0] SLOT_OCCUPIED = 2'd1;
  localparam logic [SSTATE_W-1:0] SLOT_DELETED  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SSTATE_W-1:0] state;
  } entry_t;

endpackage

// ===== rtl/lphs_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/lphs_mod.sv =====
// Multi-cycle key modulo table size, four quotient bits per cycle.
module lphs_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lphs_pkg::KEY_W-1:0]  dividend_i,
  input  logic [lphs_pkg::SIZE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [lphs_pkg::SIZE_W-1:0] rem_o
);
  import lphs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [MOD_DVD_W-1:0] dvd_q, dvd_d;
  logic [SIZE_W-1:0]    dvs_q, dvs_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W-1:0]    rem_step;
  logic [MOD_DVD_W-1:0] dvd_step;

  always_comb begin
    rem_step = rem_q;
    dvd_step = dvd_q;
    trial    = '0;
    for (int i = 0; i < MOD_BITS_PER_CYCLE; i++) begin
      trial    = {rem_step, dvd_step[MOD_DVD_W-1]};
      dvd_step = dvd_step << 1;
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_step = trial[SIZE_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = {1'b0, dividend_i};
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_step;
      rem_d = rem_step;
      cnt_d = cnt_q + MOD_CNT_W'(1);
      if (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/linear_probe_hash_set.sv =====
// A request probes p slots, p = 1 .. n, n = table size clamped to 1 .. TABLE_DEPTH; an
// unused kind answers with no modulo and no probe. One request at a time; the next can be taken
// in the cycle after the result is loaded into the output register. Each probe is one RAM read.
// Reset: table size 16, count 0; a clearing pass then empties every slot, and no request is
// taken until it ends. Configuration writes are taken at any time.
`include "assert_macros.svh"

module linear_probe_hash_set #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lphs_pkg::SIZE_W-1:0]   cfg_data_i,    // table_size
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // key[30:0], zero pad
  input  logic [lphs_pkg::KIND_W-1:0]   s_axis_tuser,  // kind[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // slot[3:0], zero pad
  output logic [lphs_pkg::STATUS_W-1:0] m_axis_tuser   // status[1:0]
);
  import lphs_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW    = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [SIZE_W-1:0]   n_use;
  logic [IDX_W-1:0]    clr_idx_q, clr_idx_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;

  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [SIZE_W-1:0]   n_q, n_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SIZE_W-1:0]   steps_q, steps_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;

  logic                accept;
  logic                mod_start, mod_done;
  logic [SIZE_W-1:0]   mod_rem;
  logic [NW-1:0]       home_ext, idx_ext, idx_inc;
  logic [IDX_W-1:0]    home_idx, idx_nxt;
  logic [SLOT_W-1:0]   idx_slot;
  logic                last_probe, out_free;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(8 - SLOT_W){1'b0}}, out_slot_q};
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    if (size_q == '0) begin
      n_use = SIZE_W'(1);
    end else if (int'(size_q) > TABLE_DEPTH) begin
      n_use = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_use = size_q;
    end
  end

  assign mod_start = accept && (s_axis_tuser != KIND_UNUSED);

  lphs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (s_axis_tdata[KEY_W-1:0]),
    .divisor_i  (n_use),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign home_ext   = NW'(mod_rem);
  assign home_idx   = home_ext[IDX_W-1:0];
  assign idx_ext    = NW'(idx_q);
  assign idx_inc    = idx_ext + NW'(1);
  assign idx_nxt    = (idx_inc == NW'(n_q)) ? '0 : idx_inc[IDX_W-1:0];
  assign idx_slot   = idx_ext[SLOT_W-1:0];
  assign last_probe = (steps_q == n_q - SIZE_W'(1));

  lphs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    clr_idx_d    = clr_idx_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    kind_d       = kind_q;
    key_d        = key_q;
    n_d          = n_q;
    idx_d        = idx_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '{key: key_q, state: SLOT_EMPTY};
    ram_re       = 1'b0;
    ram_raddr    = idx_nxt;

    if (cfg_valid_i) begin
      size_d = cfg_data_i;
    end
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = '{key: '0, state: SLOT_EMPTY};
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d  = s_axis_tuser;
          key_d   = s_axis_tdata[KEY_W-1:0];
          n_d     = n_use;
          steps_d = '0;
          if (s_axis_tuser == KIND_UNUSED) begin
            res_status_d = STATUS_NOT_FOUND;
            res_slot_d   = '0;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          ram_re    = 1'b1;
          ram_raddr = home_idx;
          idx_d     = home_idx;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_slot_d = '0;
        state_d    = ST_RESP;
        unique case (kind_q)
          KIND_INSERT: begin
            if (ram_rdata.state != SLOT_OCCUPIED) begin
              ram_we       = 1'b1;
              ram_wdata    = '{key: key_q, state: SLOT_OCCUPIED};
              res_status_d = STATUS_OK;
              res_slot_d   = idx_slot;
              if (count_q != COUNT_MAX) begin
                count_d = count_q + COUNT_W'(1);
              end
            end else if (last_probe) begin
              res_status_d = STATUS_FULL;
            end else begin
              ram_re  = 1'b1;
              idx_d   = idx_nxt;
              steps_d = steps_q + SIZE_W'(1);
              state_d = ST_CHECK;
            end
          end
          KIND_SEARCH, KIND_REMOVE: begin
            if (ram_rdata.state == SLOT_EMPTY) begin
              res_status_d = STATUS_NOT_FOUND;
            end else if (ram_rdata.state == SLOT_OCCUPIED && ram_rdata.key == key_q) begin
              res_status_d = STATUS_OK;
              res_slot_d   = idx_slot;
              if (kind_q == KIND_REMOVE) begin
                ram_we    = 1'b1;
                ram_wdata = '{key: key_q, state: SLOT_DELETED};
                if (count_q != '0) begin
                  count_d = count_q - COUNT_W'(1);
                end
              end
            end else if (last_probe) begin
              res_status_d = STATUS_NOT_FOUND;
            end else begin
              ram_re  = 1'b1;
              idx_d   = idx_nxt;
              steps_d = steps_q + SIZE_W'(1);
              state_d = ST_CHECK;
            end
          end
          default: begin
            res_status_d = STATUS_NOT_FOUND;
          end
        endcase
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      size_q      <= SIZE_RESET;
      clr_idx_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    kind_q       <= kind_d;
    key_q        <= key_d;
    n_q          <= n_d;
    idx_q        <= idx_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
  end

  `ASSERT_NEVER(a_no_rw_collision, clk_i, rst_ni, ram_we && ram_re && ram_waddr == ram_raddr, "RAM read and write hit one slot in one cycle")
  `ASSERT_PROP(a_slot_zero_on_miss, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == 8'd0), "nonzero slot on a miss")
  `ASSERT_PROP(a_count_needs_write, clk_i, rst_ni, (count_q != $past(count_q)) |-> $past(ram_we), "occupied count moved without a table write")
  `ASSERT_PROP(a_mod_done_in_mod, clk_i, rst_ni, mod_done |-> (state_q == ST_MOD), "modulo result outside the hash phase")

endmodule

// ===== test/lphs_reply_checker.sv =====
// Reply checker for the linear probing hash set: predicts every reply and compares it.
`timescale 1ns / 1ps

module lphs_reply_checker #(
  parameter int DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [lphs_pkg::SIZE_W-1:0]   cfg_data_i,   // table_size
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [31:0]                   req_data_i,   // key[30:0], zero pad
  input  logic [lphs_pkg::KIND_W-1:0]   req_user_i,   // kind[1:0]
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  logic [7:0]                    rsp_data_i,   // slot[3:0], zero pad
  input  logic [lphs_pkg::STATUS_W-1:0] rsp_user_i,   // status[1:0]
  output int                            fail_count_o,
  output int                            outstanding_o,
  output int                            replies_o,
  output int                            full_replies_o
);
  import lphs_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } hash_reply_t;

  logic [SSTATE_W-1:0] slot_state [DEPTH];
  logic [KEY_W-1:0]    slot_key   [DEPTH];
  logic [COUNT_W-1:0]  held;
  logic [SIZE_W-1:0]   table_size;

  hash_reply_t pending_replies [$];
  hash_reply_t want;
  int          fails;
  int          replies;
  int          fulls;

  // Applies one request to the table copy and returns the reply it must produce.
  function automatic hash_reply_t probe_table(input logic [KIND_W-1:0] kind,
                                              input logic [KEY_W-1:0] key);
    hash_reply_t r;
    int unsigned n;
    int unsigned idx;
    int unsigned step;
    if (table_size == 0) n = 1;
    else if (table_size > DEPTH) n = DEPTH;
    else n = 32'(table_size);
    r.status = STATUS_NOT_FOUND;
    r.slot   = '0;
    idx = key % n;
    if (kind == KIND_INSERT) begin
      r.status = STATUS_FULL;
      for (step = 0; step < n; step++) begin
        if (slot_state[idx] != SLOT_OCCUPIED) begin
          slot_state[idx] = SLOT_OCCUPIED;
          slot_key[idx]   = key;
          if (held < COUNT_MAX) held = held + 1'b1;
          r.status = STATUS_OK;
          r.slot   = idx[SLOT_W-1:0];
          break;
        end
        idx = (idx + 1 == n) ? 0 : idx + 1;
      end
    end else if (kind == KIND_SEARCH || kind == KIND_REMOVE) begin
      for (step = 0; step < n; step++) begin
        if (slot_state[idx] == SLOT_EMPTY) break;
        if (slot_state[idx] == SLOT_OCCUPIED && slot_key[idx] == key) begin
          r.status = STATUS_OK;
          r.slot   = idx[SLOT_W-1:0];
          if (kind == KIND_REMOVE) begin
            slot_state[idx] = SLOT_DELETED;
            if (held != 0) held = held - 1'b1;
          end
          break;
        end
        idx = (idx + 1 == n) ? 0 : idx + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_state[i] = SLOT_EMPTY;
        slot_key[i]   = '0;
      end
      held       = '0;
      table_size = SIZE_RESET;
      pending_replies.delete();
      fails   = 0;
      replies = 0;
      fulls   = 0;
      fail_count_o   <= 0;
      outstanding_o  <= 0;
      replies_o      <= 0;
      full_replies_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) table_size = cfg_data_i;
      if (rsp_valid_i && rsp_ready_i) begin
        replies++;
        if (rsp_user_i == STATUS_FULL) fulls++;
        if (pending_replies.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("reply %0d with nothing outstanding: status %0d tdata %h",
                     replies, rsp_user_i, rsp_data_i);
        end else begin
          want = pending_replies.pop_front();
          if (rsp_user_i !== want.status || rsp_data_i !== {4'h0, want.slot}) begin
            fails++;
            if (fails <= 10)
              $display("reply %0d: expected status %0d slot %0d, got status %0d tdata %h",
                       replies, want.status, want.slot, rsp_user_i, rsp_data_i);
          end
        end
      end
      if (req_valid_i && req_ready_i)
        pending_replies.push_back(probe_table(req_user_i, req_data_i[KEY_W-1:0]));
      fail_count_o   <= fails;
      outstanding_o  <= pending_replies.size();
      replies_o      <= replies;
      full_replies_o <= fulls;
    end
  end

endmodule

// ===== test/tb_linear_probe_hash_set.sv =====
// Testbench top for the linear probing hash set: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_linear_probe_hash_set;
  import lphs_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = 95;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SIZE_W-1:0]   cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;   // key[30:0], zero pad
  logic [KIND_W-1:0]   s_axis_tuser = '0;   // kind[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // slot[3:0], zero pad
  logic [STATUS_W-1:0] m_axis_tuser;        // status[1:0]

  int fail_count;
  int outstanding;
  int replies;
  int full_replies;
  int cycles;
  int sent;
  int random_sent;
  int size_writes;
  bit steady;

  linear_probe_hash_set uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lphs_reply_checker replies_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_i    (s_axis_tready),
    .req_data_i     (s_axis_tdata),
    .req_user_i     (s_axis_tuser),
    .rsp_valid_i    (m_axis_tvalid),
    .rsp_ready_i    (m_axis_tready),
    .rsp_data_i     (m_axis_tdata),
    .rsp_user_i     (m_axis_tuser),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .replies_o      (replies),
    .full_replies_o (full_replies)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reply side: after each transfer, stall for a random gap, or not at all in steady phases.
  always @(posedge clk_i or negedge rst_ni) begin : reply_sink
    int unsigned gap;
    int unsigned stall_left;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      gap = steady ? 0 : $urandom_range(0, 17);
      stall_left = gap;
      m_axis_tready <= (gap == 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= (stall_left == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // valid is left high after a transfer; the next call or settle_replies decides.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, key};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic settle_replies();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_writes++;
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] size;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [31:0]       raw;
    int unsigned       pick;
    int unsigned       insert_pct;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: collisions, wrap, deleted markers, unused kind, key extremes.
    send_request(KIND_INSERT, 31'd0);
    send_request(KIND_INSERT, 31'h7FFF_FFFF);
    send_request(KIND_INSERT, 31'd16);
    send_request(KIND_INSERT, 31'd31);
    send_request(KIND_SEARCH, 31'd31);
    send_request(KIND_SEARCH, 31'h7FFF_FFFF);
    send_request(KIND_REMOVE, 31'h7FFF_FFFF);
    send_request(KIND_SEARCH, 31'd31);
    send_request(KIND_SEARCH, 31'h7FFF_FFFF);
    send_request(KIND_INSERT, 31'd47);
    send_request(KIND_UNUSED, 31'd0);
    send_request(KIND_UNUSED, 31'h7FFF_FFFF);
    send_request(KIND_REMOVE, 31'd5);
    send_request(KIND_INSERT, 31'd0);
    send_request(KIND_REMOVE, 31'd0);
    send_request(KIND_SEARCH, 31'd0);
    settle_replies();
    write_size(5'd1);
    send_request(KIND_INSERT, 31'd5);
    send_request(KIND_INSERT, 31'd9);
    send_request(KIND_SEARCH, 31'd9);
    send_request(KIND_SEARCH, 31'd5);
    send_request(KIND_REMOVE, 31'd5);
    send_request(KIND_SEARCH, 31'd5);
    settle_replies();
    write_size(5'd31);
    send_request(KIND_SEARCH, 31'd31);
    send_request(KIND_SEARCH, 31'd16);

    // Random phases, each with its own table size and mix.
    for (int phase = 0; phase < PHASES; phase++) begin
      unique case (phase)
        0:       size = 5'd16;
        1:       size = 5'd5;
        2:       size = 5'd0;
        3:       size = 5'd31;
        4:       size = 5'd2;
        5:       size = 5'd17;
        6:       size = 5'd1;
        default: size = SIZE_W'($urandom_range(0, 31));
      endcase
      settle_replies();
      write_size(size);
      steady = (phase % 4 == 3);
      insert_pct = (phase % 2 == 0) ? 53 : 28;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) kind = KIND_UNUSED;
        else if (pick < insert_pct) kind = KIND_INSERT;
        else if (pick < insert_pct + 30) kind = KIND_SEARCH;
        else kind = KIND_REMOVE;
        pick = $urandom_range(0, 99);
        raw = $urandom;
        if (pick < 75) key = KEY_W'($urandom_range(0, 47));
        else if (pick < 90) key = raw[KEY_W-1:0];
        else key = KEY_W'(32'h7FFF_FFFF - $urandom_range(0, 40));
        send_request(kind, key);
        random_sent++;
      end
    end
    steady = 1'b0;
    settle_replies();

    $display("%0d requests (%0d random) over %0d table-size writes, sizes 0 to 31",
             sent, random_sent, size_writes);
    $display("%0d replies compared, %0d of them table-full", replies, full_replies);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== linear_probe_hash_set.f =====
+incdir+rtl
rtl/lphs_pkg.sv
rtl/lphs_ram.sv
rtl/lphs_mod.sv
rtl/linear_probe_hash_set.sv
test/lphs_reply_checker.sv
test/tb_linear_probe_hash_set.sv
